// ===== rtl/core/fba_pkg.sv =====
`default_nettype none

package fba_pkg;

   localparam int FRAME_W     = 12;
   localparam int WORD_BITS   = 32;
   localparam int BIT_IDX_W   = 5;
   localparam int WORD_IDX_W  = FRAME_W - BIT_IDX_W;
   localparam int FIELD_WORDS = 128;
   localparam int CSR_W       = 8;
   localparam int OP_W        = 2;
   localparam int STAT_W      = 2;

   localparam logic [CSR_W-1:0] WORDS_RESET = 8'd128;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOP   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [FRAME_W-1:0] page_frame;
      logic               kernel_page;
      logic               rw_wanted;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] new_frame;
      logic               present;
      logic               writable;
      logic               user_mode;
      logic               frame_used;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic                 found;
      logic [WORD_BITS-1:0] free_bit;
      logic [BIT_IDX_W-1:0] bit_idx;
   } zero_hit_type;

endpackage

`default_nettype wire

// ===== rtl/core/frame_bitmap_allocator.sv =====
`default_nettype none

// Page-frame allocator over a used/free bitmap, one bit per frame, held in
// a single-port-write, registered-read RAM of BITMAP_WORDS 32-bit words.
//
// Request channel: drive req_data and pulse start while busy is low; the
// request is taken on that edge. One response follows on rsp_data, marked by
// rsp_valid for exactly one cycle; the receiver must take it then.
// Configuration: csr_wdata sets how many bitmap words allocation searches;
// csr_ready is always high, so a write lands on any edge with csr_valid.
//
// Work per request, from the accepting edge to the rsp_valid cycle:
//   - held-entry allocate, free of frame zero or of a frame beyond the
//     bitmap, test beyond the bitmap, unused opcode: answered from idle
//   - free or test of a frame in the bitmap: read, then write back or report
//   - allocate of an empty entry: words are read from 0 up to the first clear
//     bit; STAT_EMPTY when none of the n searched words has one.
//     One RAM word is read per cycle and checked in the next
// A new request may be started in the cycle rsp_valid is high.
//
// Reset: a clearing pass writes every RAM word to zero with busy high;
// configuration writes are still taken during the pass.
module frame_bitmap_allocator #(
   parameter int BITMAP_WORDS = 128
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire fba_pkg::req_type            req_data,
   output      logic                        rsp_valid,
   output      fba_pkg::rsp_type            rsp_data,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [fba_pkg::CSR_W-1:0]   csr_wdata
);
   import fba_pkg::*;

   localparam int ADDR_W   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int SCAN_MAX = (BITMAP_WORDS < FIELD_WORDS) ? BITMAP_WORDS : FIELD_WORDS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_WORDS - 1);
   localparam logic [CSR_W-1:0]  SCAN_CAP  = CSR_W'(SCAN_MAX);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_RMW   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [CSR_W-1:0]      words_ff;
   logic [CSR_W-1:0]      scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [WORD_IDX_W-1:0] pend_word_ff, pend_word_in;
   req_type               req_ff, req_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_BITS-1:0]  rd_data;
   zero_hit_type          zhit;

   logic [CSR_W-1:0]      bound;
   logic                  issue;
   logic [WORD_IDX_W-1:0] new_word;
   logic                  new_in_map;
   logic [WORD_IDX_W-1:0] held_word;
   logic [WORD_BITS-1:0]  held_mask;

   fba_ram #(
      .DEPTH  (BITMAP_WORDS),
      .ADDR_W (ADDR_W),
      .WIDTH  (WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fba_zero_find u_find (
      .word (rd_data),
      .hit  (zhit)
   );

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // search bound: min(words_in_use, BITMAP_WORDS, 128)
   assign bound = (words_ff > SCAN_CAP) ? SCAN_CAP : words_ff;
   assign issue = (scan_ff < bound);

   assign new_word   = req_data.page_frame[FRAME_W-1:BIT_IDX_W];
   assign new_in_map = (32'(new_word) < 32'(BITMAP_WORDS));
   assign held_word  = req_ff.page_frame[FRAME_W-1:BIT_IDX_W];
   assign held_mask  = WORD_BITS'(1) << req_ff.page_frame[BIT_IDX_W-1:0];

   // read address: request word while idle, scan pointer while scanning
   always_comb begin
      if (state_ff == S_SCAN) begin
         rd_addr = ADDR_W'(scan_ff);
      end else begin
         rd_addr = ADDR_W'(new_word);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_word_in = pend_word_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one word a cycle
            wr_en  = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.opcode)
                  OP_ALLOC: begin
                     if (req_data.page_frame != '0) begin
                        // entry already holds a frame: report it back
                        rsp_in.new_frame = req_data.page_frame;
                        rsp_in.status    = STAT_NOP;
                        rsp_valid_in     = 1'b1;
                     end else begin
                        scan_in  = '0;
                        pend_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (req_data.page_frame == '0) begin
                        rsp_in.status = STAT_NOP;
                        rsp_valid_in  = 1'b1;
                     end else if (!new_in_map) begin
                        rsp_in.status = STAT_DONE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_RMW;
                     end
                  end
                  OP_TEST: begin
                     if (new_in_map) begin
                        state_in = S_RMW;
                     end else begin
                        rsp_in.new_frame = req_data.page_frame;
                        rsp_in.status    = STAT_DONE;
                        rsp_valid_in     = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_NOP;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // read word scan_ff while checking the word read last cycle
            if (pend_ff && zhit.found) begin
               wr_en            = 1'b1;
               wr_addr          = ADDR_W'(pend_word_ff);
               wr_data          = rd_data | zhit.free_bit;
               rsp_in.new_frame = {pend_word_ff, zhit.bit_idx};
               rsp_in.present   = 1'b1;
               rsp_in.writable  = req_ff.rw_wanted;
               rsp_in.user_mode = ~req_ff.kernel_page;
               rsp_in.status    = STAT_DONE;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else if (!issue) begin
               // bound reached with no clear bit
               rsp_in.status = STAT_EMPTY;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               scan_in      = scan_ff + CSR_W'(1);
               pend_in      = 1'b1;
               pend_word_in = WORD_IDX_W'(scan_ff);
            end
         end

         S_RMW: begin
            // word is back from the RAM: write back for free, report for test
            if (req_ff.opcode == OP_FREE) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(held_word);
               wr_data = rd_data & ~held_mask;
            end else begin
               rsp_in.new_frame  = req_ff.page_frame;
               rsp_in.frame_used = |(rd_data & held_mask);
            end
            rsp_in.status = STAT_DONE;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the search bound register; writes land in any state
   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= WORDS_RESET;
      end else if (csr_valid && csr_ready) begin
         words_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      pend_word_ff <= pend_word_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither worked on nor answered");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("bitmap written while idle");

   a_alloc_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.present) |-> (rsp_data.status == STAT_DONE))
      else $error("present set on a failed request");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fba_ram.sv =====
`default_nettype none

module fba_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7,
   parameter int WIDTH  = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/fba_zero_find.sv =====
`default_nettype none

module fba_zero_find (
   input  wire logic [fba_pkg::WORD_BITS-1:0] word,
   output      fba_pkg::zero_hit_type         hit
);
   import fba_pkg::*;

   logic [WORD_BITS-1:0] inv;
   logic [WORD_BITS-1:0] iso;

   // isolate the lowest clear bit of the word
   assign inv = ~word;
   assign iso = inv & (~inv + WORD_BITS'(1));

   always_comb begin
      hit.found    = |inv;
      hit.free_bit = iso;
      hit.bit_idx  = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (iso[i]) begin
            hit.bit_idx = hit.bit_idx | BIT_IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_frame_bitmap_allocator.sv =====
`timescale 1ns / 100ps

module tb_frame_bitmap_allocator;
   import fba_pkg::*;

   localparam int MAP_WORDS    = 128;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = MAP_WORDS + 16;
   localparam int PHASE_ITEMS  = 180;

   // The package names three opcodes; the fourth encoding must be a no-op.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // One entry of the stimulus list: either a request or a register write.
   typedef struct packed {
      logic              is_write;
      logic [CSR_W-1:0]  words;
      req_type           rq;
   } pending_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_data  = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata = '0;

   // Stimulus waiting to go out, and responses predicted but not yet seen.
   pending_type pending[$];
   rsp_type     expected_rsps[$];

   // Predictor state: shadow bitmap and the current search-width setting.
   logic [WORD_BITS-1:0] frame_map[MAP_WORDS] = '{default: '0};
   int                   words_cfg = int'(WORDS_RESET);

   int error_count = 0;
   int cycle_count = 0;
   int gap_left    = 0;
   int burst_left  = 0;

   int n_requests  = 0;
   int n_alloc_ok  = 0;
   int n_exhausted = 0;
   int n_held      = 0;
   int n_frees     = 0;
   int n_tests     = 0;
   int n_writes    = 0;

   frame_bitmap_allocator #(
      .BITMAP_WORDS(MAP_WORDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Work out the response to one request and update the shadow bitmap the
   // way the allocator must.
   function automatic rsp_type predict_response(input req_type rq);
      rsp_type rs;
      int      limit;
      int      f;
      logic    hit;
      int      word;
      rs    = '0;
      word  = int'(rq.page_frame[FRAME_W-1:BIT_IDX_W]);
      limit = words_cfg;
      if (limit > MAP_WORDS) limit = MAP_WORDS;
      if (limit > FIELD_WORDS) limit = FIELD_WORDS;
      case (rq.opcode)
         OP_ALLOC: begin
            if (rq.page_frame != '0) begin
               // entry already holds a frame: hand it back untouched
               rs.new_frame = rq.page_frame;
               rs.status    = STAT_NOP;
            end else begin
               // first fit: lowest clear bit within the searched words
               hit = 1'b0;
               f   = 0;
               while (!hit && f < limit * WORD_BITS) begin
                  if (!frame_map[f / WORD_BITS][f % WORD_BITS]) hit = 1'b1;
                  else f++;
               end
               if (hit) begin
                  frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                  rs.new_frame = f[FRAME_W-1:0];
                  rs.present   = 1'b1;
                  rs.writable  = rq.rw_wanted;
                  rs.user_mode = ~rq.kernel_page;
                  rs.status    = STAT_DONE;
               end else begin
                  rs.status = STAT_EMPTY;
               end
            end
         end
         OP_FREE: begin
            if (rq.page_frame == '0) begin
               rs.status = STAT_NOP;
            end else begin
               if (word < MAP_WORDS)
                  frame_map[word][rq.page_frame[BIT_IDX_W-1:0]] = 1'b0;
               rs.status = STAT_DONE;
            end
         end
         OP_TEST: begin
            rs.new_frame  = rq.page_frame;
            rs.frame_used = (word < MAP_WORDS) ?
                            frame_map[word][rq.page_frame[BIT_IDX_W-1:0]] : 1'b0;
            rs.status     = STAT_DONE;
         end
         default: begin
            rs.status = STAT_NOP;
         end
      endcase
      return rs;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic add_request(input logic [OP_W-1:0] op, input int pf,
                              input logic kern, input logic wr);
      pending_type it;
      it                = '0;
      it.rq.opcode      = op;
      it.rq.page_frame  = pf[FRAME_W-1:0];
      it.rq.kernel_page = kern;
      it.rq.rw_wanted   = wr;
      pending.push_back(it);
   endtask

   task automatic add_write(input int words);
      pending_type it;
      it          = '0;
      it.is_write = 1'b1;
      it.words    = words[CSR_W-1:0];
      pending.push_back(it);
   endtask

   // Queue one register write and a phase of random requests. Most requests
   // are allocations of empty entries plus frees and tests aimed at the low
   // frames that those allocations reach; the rest are held-entry allocations and noise.
   task automatic add_random_phase(input int words, input int count);
      int bound;
      int span;
      int pick;
      int near;
      add_write(words);
      bound = (words > FIELD_WORDS) ? FIELD_WORDS : words;
      span  = (bound == 0) ? 63 : WORD_BITS * ((bound < 16) ? bound : 16) + 31;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         near = $urandom_range(0, span);
         if (pick < 40)
            add_request(OP_ALLOC, 0, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
         else if (pick < 48)
            add_request(OP_ALLOC, $urandom_range(1, 4095), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
         else if (pick < 73)
            add_request(OP_FREE, near, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
         else if (pick < 90)
            add_request(OP_TEST, near, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
         else
            add_request(OP_W'($urandom_range(0, 3)), $urandom_range(0, 4095),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Driver: present the head of the stimulus list on the falling edge.
   // Requests go out in bursts with random gaps; a register write waits
   // until every outstanding response has come back.
   always @(negedge clock) begin : drive_requests
      logic             nxt_start;
      logic             nxt_csr;
      req_type          nxt_data;
      logic [CSR_W-1:0] nxt_wdata;
      nxt_start = 1'b0;
      nxt_csr   = 1'b0;
      nxt_data  = req_data;
      nxt_wdata = csr_wdata;
      if (!reset && pending.size() != 0) begin
         if (pending[0].is_write) begin
            // hold the write off while the allocator still owes responses
            if (expected_rsps.size() == 0) begin
               nxt_csr   = 1'b1;
               nxt_wdata = pending[0].words;
            end
         end else if (gap_left > 0) begin
            gap_left--;
         end else begin
            nxt_start = 1'b1;
            nxt_data  = pending[0].rq;
            if (burst_left <= 1) begin
               // end of burst: pick the next gap, sometimes none at all
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               burst_left = $urandom_range(1, 24);
            end else begin
               burst_left--;
            end
         end
      end
      start     <= nxt_start;
      req_data  <= nxt_data;
      csr_valid <= nxt_csr;
      csr_wdata <= nxt_wdata;
   end

   // Monitor: on the rising edge, check a response against the oldest
   // prediction, then record any request or register write taken here.
   always @(posedge clock) begin : watch_ports
      rsp_type     want;
      rsp_type     fresh;
      pending_type it;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none outstanding: expected none, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("new_frame",  32'(want.new_frame),  32'(rsp_data.new_frame));
               check_field("present",    32'(want.present),    32'(rsp_data.present));
               check_field("writable",   32'(want.writable),   32'(rsp_data.writable));
               check_field("user_mode",  32'(want.user_mode),  32'(rsp_data.user_mode));
               check_field("frame_used", 32'(want.frame_used), 32'(rsp_data.frame_used));
               check_field("status",     32'(want.status),     32'(rsp_data.status));
            end
         end
         if (csr_valid && csr_ready && pending.size() != 0 && pending[0].is_write) begin
            it        = pending.pop_front();
            words_cfg = int'(csr_wdata);
            n_writes++;
         end
         if (start && !busy && pending.size() != 0 && !pending[0].is_write) begin
            it    = pending.pop_front();
            fresh = predict_response(it.rq);
            expected_rsps.push_back(fresh);
            n_requests++;
            case (it.rq.opcode)
               OP_ALLOC: begin
                  if (fresh.status == STAT_DONE) n_alloc_ok++;
                  else if (fresh.status == STAT_EMPTY) n_exhausted++;
                  else n_held++;
               end
               OP_FREE: n_frees++;
               OP_TEST: n_tests++;
               default: ;
            endcase
         end
      end
   end

   // Watchdog: abandon a run that stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // Directed part, under the reset search width: first fit from frame
      // zero, entry bits, held entries, frees of frame zero and of clear
      // bits, reuse of a freed frame, the unused opcode, extreme frames.
      add_request(OP_TEST,   0,    1'b0, 1'b0);
      add_request(OP_ALLOC,  0,    1'b0, 1'b1);
      add_request(OP_ALLOC,  0,    1'b1, 1'b0);
      add_request(OP_ALLOC,  4095, 1'b1, 1'b1);
      add_request(OP_ALLOC,  1,    1'b0, 1'b0);
      add_request(OP_TEST,   0,    1'b1, 1'b1);
      add_request(OP_TEST,   4095, 1'b0, 1'b0);
      add_request(OP_TEST,   1,    1'b0, 1'b1);
      add_request(OP_FREE,   0,    1'b1, 1'b1);
      add_request(OP_FREE,   4095, 1'b0, 1'b0);
      add_request(OP_FREE,   1,    1'b0, 1'b0);
      add_request(OP_TEST,   1,    1'b0, 1'b0);
      add_request(OP_FREE,   1,    1'b1, 1'b0);
      add_request(OP_ALLOC,  0,    1'b0, 1'b0);
      add_request(OP_UNUSED, 4095, 1'b1, 1'b1);
      add_request(OP_UNUSED, 0,    1'b0, 1'b0);
      add_request(OP_ALLOC,  0,    1'b1, 1'b1);
      add_request(OP_TEST,   2048, 1'b1, 1'b0);
      // zero search width: every allocation must report exhaustion
      add_write(0);
      add_request(OP_ALLOC,  0,    1'b1, 1'b1);
      add_request(OP_TEST,   0,    1'b0, 1'b0);
      // Random phases: narrow widths fill up and exhaust quickly, wide ones
      // (including values past the bitmap) exercise the clamp.
      add_random_phase(1,   PHASE_ITEMS);
      add_random_phase(2,   PHASE_ITEMS);
      add_random_phase(255, PHASE_ITEMS);
      add_random_phase(3,   PHASE_ITEMS);
      add_random_phase(int'(WORDS_RESET), PHASE_ITEMS);
      add_random_phase($urandom_range(1, 8), PHASE_ITEMS);
      add_random_phase(0,   PHASE_ITEMS / 4);
      add_random_phase(1,   PHASE_ITEMS);
      add_random_phase($urandom_range(0, 255), PHASE_ITEMS);

      // Hold reset, then release it on a falling edge.
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      // Let a long scan's worth of cycles pass to catch stray responses.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests in %0d cycles, %0d register writes",
               n_requests, cycle_count, n_writes);
      $display("summary: %0d allocated, %0d exhausted, %0d held, %0d frees, %0d tests",
               n_alloc_ok, n_exhausted, n_held, n_frees, n_tests);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fba_pkg.sv
rtl/core/fba_ram.sv
rtl/core/fba_zero_find.sv
rtl/core/frame_bitmap_allocator.sv
sim/tb_frame_bitmap_allocator.sv
